// File: rtl/htlp_pkg.sv
// ----------------------------------------------------------------------------
// htlp_pkg
// Shared types and constants for the linear-probing hash table.
// ----------------------------------------------------------------------------
`default_nettype none

package htlp_pkg;

    localparam int SLOT_COUNT = 256;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int SIZE_W     = SLOT_W + 1;
    localparam int KEY_W      = 32;
    localparam int PAY_W      = 32;

    localparam logic [KEY_W-1:0] HASH_MASK = 32'h7FFF_FFFF;
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(SLOT_COUNT);
    localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(SLOT_COUNT);

    // remainder unit retires this many dividend bits per cycle
    localparam int DIV_STEP_BITS = 4;
    localparam int DIV_CYCLES    = KEY_W / DIV_STEP_BITS;
    localparam int DIV_CNT_W     = $clog2(DIV_CYCLES);

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_DIRECT = 2'd1;
    localparam logic [1:0] REQ_PROBE  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HASH,
        S_READ,
        S_CHECK
    } state_t;

    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [SLOT_W-1:0] addr;
        logic [KEY_W-1:0]  wr_key;
        logic [PAY_W-1:0]  wr_payload;
    } mem_req_t;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } mem_rsp_t;

endpackage

`default_nettype wire

// File: rtl/htlp_mod_unit.sv
// ----------------------------------------------------------------------------
// htlp_mod_unit
// Iterative remainder unit: key modulo table size, radix-16 restoring steps.
// ----------------------------------------------------------------------------
`default_nettype none

module htlp_mod_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [htlp_pkg::KEY_W-1:0]     dividend,
    input  wire logic [htlp_pkg::SIZE_W-1:0]    divisor,
    output logic                                done,
    output logic [htlp_pkg::SIZE_W-1:0]         rem
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [htlp_pkg::DIV_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [htlp_pkg::KEY_W-1:0]        dvd_reg, dvd_next;
    logic [htlp_pkg::SIZE_W-1:0]       div_reg, div_next;
    logic [htlp_pkg::SIZE_W-1:0]       rem_reg, rem_next;
    logic [htlp_pkg::SIZE_W-1:0]       step_rem;
    logic [htlp_pkg::KEY_W-1:0]        step_dvd;

    // four dependent compare/subtract steps on a 9-bit partial remainder
    always_comb
    begin
        logic [htlp_pkg::SIZE_W:0] t;
        step_rem = rem_reg;
        step_dvd = dvd_reg;
        t        = '0;
        for (int j = 0; j < htlp_pkg::DIV_STEP_BITS; j++)
        begin
            t = {step_rem, step_dvd[htlp_pkg::KEY_W-1]};
            if (t >= {1'b0, div_reg})
            begin
                t = t - {1'b0, div_reg};
            end
            step_rem = t[htlp_pkg::SIZE_W-1:0];
            step_dvd = {step_dvd[htlp_pkg::KEY_W-2:0], 1'b0};
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend & htlp_pkg::HASH_MASK;
            div_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = step_dvd;
            rem_next = step_rem;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == htlp_pkg::DIV_CNT_W'(htlp_pkg::DIV_CYCLES - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

// File: rtl/htlp_slot_mem.sv
// ----------------------------------------------------------------------------
// htlp_slot_mem
// Slot store: valid flags in flops, key and payload in a one-port memory.
// ----------------------------------------------------------------------------
`default_nettype none

module htlp_slot_mem (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire htlp_pkg::mem_req_t req,
    output htlp_pkg::mem_rsp_t      rsp
);

    logic [htlp_pkg::SLOT_COUNT-1:0] valid_reg;
    logic [htlp_pkg::KEY_W-1:0]      key_mem [htlp_pkg::SLOT_COUNT];
    logic [htlp_pkg::PAY_W-1:0]      pay_mem [htlp_pkg::SLOT_COUNT];
    logic                            rd_valid_reg;
    logic [htlp_pkg::KEY_W-1:0]      rd_key_reg;
    logic [htlp_pkg::PAY_W-1:0]      rd_pay_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            key_mem[req.addr] <= req.wr_key;
            pay_mem[req.addr] <= req.wr_payload;
        end
        if (req.rd_en)
        begin
            rd_key_reg <= key_mem[req.addr];
            rd_pay_reg <= pay_mem[req.addr];
        end
    end

    assign rsp.valid   = rd_valid_reg;
    assign rsp.key     = rd_key_reg;
    assign rsp.payload = rd_pay_reg;

endmodule

`default_nettype wire

// File: rtl/hash_table_linear_probe.sv
// ----------------------------------------------------------------------------
// hash_table_linear_probe
// Open-addressing record table with insert, direct lookup and linear probing.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The answer appears on
// ok and found_payload for one cycle with done high and must be captured then,
// there is no back-pressure. Busy falls in that same cycle, so the next request
// can go at the edge that takes the answer. Every request first passes through
// the shared remainder unit (4 key bits per cycle) to find the home slot: the
// hash state starts the unit and acts on the remainder when it is done. An
// insert or unknown request is answered from that state, a direct lookup reads
// one slot first. A probing lookup reads one visited slot at a time through
// the single memory port and visits at most table-size slots.
// The table is empty right after reset, no clearing pass is needed.
`default_nettype none

module hash_table_linear_probe (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [htlp_pkg::SIZE_W-1:0]  cfg_data,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [1:0]                   req_type,
    input  wire logic signed [31:0]           key,
    input  wire logic [31:0]                  payload,
    output logic                              done,
    output logic                              ok,
    output logic [31:0]                       found_payload
);

    htlp_pkg::state_t                  state_reg, state_next;
    logic [htlp_pkg::SIZE_W-1:0]       size_cfg_reg;
    logic [htlp_pkg::SIZE_W-1:0]       size_eff;
    logic [htlp_pkg::SIZE_W-1:0]       count_reg, count_next;
    logic [1:0]                        req_reg, req_next;
    logic [htlp_pkg::KEY_W-1:0]        key_reg, key_next;
    logic [htlp_pkg::PAY_W-1:0]        pay_reg, pay_next;
    logic [htlp_pkg::SLOT_W-1:0]       pos_reg, pos_next;
    logic [htlp_pkg::SIZE_W-1:0]       visit_reg, visit_next;
    logic                              done_reg, done_next;
    logic                              ok_reg, ok_next;
    logic [htlp_pkg::PAY_W-1:0]        found_reg, found_next;
    logic                              div_start;
    logic                              div_done;
    logic [htlp_pkg::SIZE_W-1:0]       div_rem;
    logic [htlp_pkg::SIZE_W-1:0]       pos_inc;
    logic [htlp_pkg::SIZE_W-1:0]       visit_inc;
    htlp_pkg::mem_req_t                mreq;
    htlp_pkg::mem_rsp_t                mrsp;

    // size zero acts as one, anything past the slot count is clamped
    always_comb
    begin
        if (size_cfg_reg == '0)
        begin
            size_eff = htlp_pkg::SIZE_W'(1);
        end
        else if (size_cfg_reg > htlp_pkg::SIZE_MAX)
        begin
            size_eff = htlp_pkg::SIZE_MAX;
        end
        else
        begin
            size_eff = size_cfg_reg;
        end
    end

    htlp_mod_unit u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (key_reg),
        .divisor  (size_eff),
        .done     (div_done),
        .rem      (div_rem)
    );

    htlp_slot_mem u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .rsp   (mrsp)
    );

    assign pos_inc   = {1'b0, pos_reg} + 1'b1;
    assign visit_inc = visit_reg + 1'b1;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        req_next   = req_reg;
        key_next   = key_reg;
        pay_next   = pay_reg;
        pos_next   = pos_reg;
        visit_next = visit_reg;
        done_next  = 1'b0;
        ok_next    = ok_reg;
        found_next = found_reg;
        div_start  = 1'b0;
        mreq.wr_en      = 1'b0;
        mreq.rd_en      = 1'b0;
        mreq.addr       = pos_reg;
        mreq.wr_key     = key_reg;
        mreq.wr_payload = pay_reg;

        case (state_reg)
            htlp_pkg::S_IDLE:
            begin
                if (start)
                begin
                    req_next   = req_type;
                    key_next   = key;
                    pay_next   = payload;
                    state_next = htlp_pkg::S_HASH;
                end
            end
            htlp_pkg::S_HASH:
            begin
                // key_reg is loaded; kick the divider on entry, wait for done
                if (visit_reg == '1)
                begin
                    if (div_done)
                    begin
                        pos_next   = div_rem[htlp_pkg::SLOT_W-1:0];
                        visit_next = '0;
                        case (req_reg)
                            htlp_pkg::REQ_INSERT:
                            begin
                                ok_next    = 1'b0;
                                found_next = '0;
                                if (count_reg < size_eff)
                                begin
                                    mreq.wr_en = 1'b1;
                                    mreq.addr  = div_rem[htlp_pkg::SLOT_W-1:0];
                                    count_next = count_reg + 1'b1;
                                    ok_next    = 1'b1;
                                end
                                done_next  = 1'b1;
                                state_next = htlp_pkg::S_IDLE;
                            end
                            htlp_pkg::REQ_DIRECT,
                            htlp_pkg::REQ_PROBE:
                            begin
                                state_next = htlp_pkg::S_READ;
                            end
                            default:
                            begin
                                ok_next    = 1'b0;
                                found_next = '0;
                                done_next  = 1'b1;
                                state_next = htlp_pkg::S_IDLE;
                            end
                        endcase
                    end
                end
                else
                begin
                    div_start  = 1'b1;
                    visit_next = '1;
                end
            end
            htlp_pkg::S_READ:
            begin
                mreq.rd_en = 1'b1;
                state_next = htlp_pkg::S_CHECK;
            end
            htlp_pkg::S_CHECK:
            begin
                ok_next    = 1'b0;
                found_next = '0;
                if (req_reg == htlp_pkg::REQ_DIRECT)
                begin
                    // direct lookup: any valid home slot is a hit
                    if (mrsp.valid)
                    begin
                        ok_next    = 1'b1;
                        found_next = mrsp.payload;
                    end
                    done_next  = 1'b1;
                    state_next = htlp_pkg::S_IDLE;
                end
                else if (!mrsp.valid)
                begin
                    done_next  = 1'b1;
                    state_next = htlp_pkg::S_IDLE;
                end
                else if (mrsp.key == key_reg)
                begin
                    ok_next    = 1'b1;
                    found_next = mrsp.payload;
                    done_next  = 1'b1;
                    state_next = htlp_pkg::S_IDLE;
                end
                else if (visit_inc >= size_eff)
                begin
                    // every slot in use visited
                    done_next  = 1'b1;
                    state_next = htlp_pkg::S_IDLE;
                end
                else
                begin
                    visit_next = visit_inc;
                    if (pos_inc >= size_eff)
                    begin
                        pos_next = '0;
                    end
                    else
                    begin
                        pos_next = pos_inc[htlp_pkg::SLOT_W-1:0];
                    end
                    state_next = htlp_pkg::S_READ;
                end
            end
            default:
            begin
                state_next = htlp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= htlp_pkg::S_IDLE;
            size_cfg_reg <= htlp_pkg::SIZE_RESET;
            count_reg    <= '0;
            done_reg     <= 1'b0;
            visit_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            if (state_reg == htlp_pkg::S_IDLE)
            begin
                visit_reg <= '0;
            end
            else
            begin
                visit_reg <= visit_next;
            end
            if (cfg_we)
            begin
                size_cfg_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        key_reg   <= key_next;
        pay_reg   <= pay_next;
        pos_reg   <= pos_next;
        ok_reg    <= ok_next;
        found_reg <= found_next;
    end

    assign busy          = (state_reg != htlp_pkg::S_IDLE);
    assign done          = done_reg;
    assign ok            = ok_reg;
    assign found_payload = found_reg;

endmodule

`default_nettype wire

// File: tb/sv/hash_table_linear_probe_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hash_table_linear_probe_test
// Self-checking bench for the linear-probing record table. A short directed
// sequence hits empty, full and one-slot tables, size clamping, overwrites,
// exhausted probes and the unknown request. Random phases then follow at
// several table sizes, using keys that repeat, collide or differ only in the
// sign bit. Each answer is checked against a behavioral shadow or its plan row.
// ----------------------------------------------------------------------------
module hash_table_linear_probe_test;
    import htlp_pkg::*;

    localparam logic [1:0] REQ_UNKNOWN     = 2'd3;
    localparam int         RANDOM_ITEMS    = 1650;
    localparam int         NUM_PHASES      = 12;
    localparam int         ITEMS_PER_PHASE = RANDOM_ITEMS / NUM_PHASES;
    localparam int         SETTLE_CYCLES   = 4;
    localparam int         DRAIN_CYCLES    = 600;
    localparam int         POOL_DEPTH      = 64;
    localparam int         MAX_PRINTED     = 100;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_REQ,
        ROW_REQ_TYPED
    } row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [1:0]        req;
        logic [KEY_W-1:0]  key;
        logic [PAY_W-1:0]  pay;
        logic [SIZE_W-1:0] size;
        logic              ok;
        logic [PAY_W-1:0]  found;
    } plan_row_t;

    typedef struct {
        int               seq;
        logic             ok;
        logic [PAY_W-1:0] found;
    } answer_t;

    // typed answers only where they are obvious; ROW_REQ rows use the shadow
    localparam plan_row_t PLAN [24] = '{
        '{ROW_REQ_TYPED, REQ_PROBE,   32'h0000_0005, 32'h0000_0000, 9'd0,   1'b0, 32'h0},
        '{ROW_REQ_TYPED, REQ_DIRECT,  32'h0000_0005, 32'h0000_0000, 9'd0,   1'b0, 32'h0},
        '{ROW_CFG,       REQ_INSERT,  32'h0000_0000, 32'h0000_0000, 9'd1,   1'b0, 32'h0},
        '{ROW_REQ_TYPED, REQ_INSERT,  32'h8000_0000, 32'hFFFF_FFFF, 9'd0,   1'b1, 32'h0},
        '{ROW_REQ_TYPED, REQ_DIRECT,  32'h0000_0007, 32'h0000_0000, 9'd0,   1'b1,
          32'hFFFF_FFFF},
        '{ROW_REQ_TYPED, REQ_PROBE,   32'h0000_0007, 32'h0000_0000, 9'd0,   1'b0, 32'h0},
        '{ROW_REQ_TYPED, REQ_PROBE,   32'h8000_0000, 32'h0000_0000, 9'd0,   1'b1,
          32'hFFFF_FFFF},
        '{ROW_REQ_TYPED, REQ_INSERT,  32'h0000_0001, 32'h0000_1234, 9'd0,   1'b0, 32'h0},
        '{ROW_REQ_TYPED, REQ_UNKNOWN, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 9'd0,   1'b0, 32'h0},
        '{ROW_CFG,       REQ_INSERT,  32'h0000_0000, 32'h0000_0000, 9'd0,   1'b0, 32'h0},
        '{ROW_REQ_TYPED, REQ_PROBE,   32'h0000_0000, 32'h0000_0000, 9'd0,   1'b0, 32'h0},
        '{ROW_REQ_TYPED, REQ_DIRECT,  32'h0000_0000, 32'h0000_0000, 9'd0,   1'b1,
          32'hFFFF_FFFF},
        '{ROW_CFG,       REQ_INSERT,  32'h0000_0000, 32'h0000_0000, 9'd511, 1'b0, 32'h0},
        '{ROW_REQ_TYPED, REQ_INSERT,  32'h7FFF_FFFF, 32'h0000_0000, 9'd0,   1'b1, 32'h0},
        '{ROW_REQ_TYPED, REQ_INSERT,  32'hFFFF_FFFF, 32'hA5A5_5A5A, 9'd0,   1'b1, 32'h0},
        '{ROW_REQ,       REQ_PROBE,   32'hFFFF_FFFF, 32'h0000_0000, 9'd0,   1'b0, 32'h0},
        '{ROW_REQ,       REQ_PROBE,   32'h7FFF_FFFF, 32'h0000_0000, 9'd0,   1'b0, 32'h0},
        '{ROW_REQ_TYPED, REQ_INSERT,  32'h0000_0100, 32'h0000_0001, 9'd0,   1'b1, 32'h0},
        '{ROW_REQ,       REQ_DIRECT,  32'h0000_0000, 32'h0000_0000, 9'd0,   1'b0, 32'h0},
        '{ROW_CFG,       REQ_INSERT,  32'h0000_0000, 32'h0000_0000, 9'd256, 1'b0, 32'h0},
        '{ROW_REQ_TYPED, REQ_INSERT,  32'h0000_0002, 32'h5A5A_A5A5, 9'd0,   1'b1, 32'h0},
        '{ROW_REQ,       REQ_PROBE,   32'h0000_0102, 32'h0000_0000, 9'd0,   1'b0, 32'h0},
        '{ROW_REQ,       REQ_PROBE,   32'h0000_0002, 32'h0000_0000, 9'd0,   1'b0, 32'h0},
        '{ROW_REQ,       REQ_DIRECT,  32'h8000_0002, 32'h0000_0000, 9'd0,   1'b0, 32'h0}
    };

    localparam logic [SIZE_W-1:0] PHASE_SIZES [NUM_PHASES] = '{
        9'd3, 9'd9, 9'd0, 9'd17, 9'd64, 9'd257, 9'd130, 9'd511, 9'd1, 9'd256, 9'd200, 9'd256
    };

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 cfg_we   = 1'b0;
    logic [SIZE_W-1:0]    cfg_data = '0;
    logic                 start    = 1'b0;
    logic [1:0]           req_type = REQ_INSERT;
    logic signed [31:0]   key      = '0;
    logic [31:0]          payload  = '0;
    wire logic            busy;
    wire logic            done;
    wire logic            ok;
    wire logic [31:0]     found_payload;

    // shadow of the record table
    logic                 shadow_valid   [SLOT_COUNT];
    logic [KEY_W-1:0]     shadow_key     [SLOT_COUNT];
    logic [PAY_W-1:0]     shadow_payload [SLOT_COUNT];
    int unsigned          shadow_count;
    logic [SIZE_W-1:0]    shadow_size;

    answer_t              answers_due [$];
    logic [KEY_W-1:0]     key_pool [$];
    int                   items_sent = 0;
    int                   err_count  = 0;

    hash_table_linear_probe dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .key           (key),
        .payload       (payload),
        .done          (done),
        .ok            (ok),
        .found_payload (found_payload)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int unsigned live_size();
        if (shadow_size == 0)
            return 1;
        if (shadow_size > SIZE_MAX)
            return SLOT_COUNT;
        return shadow_size;
    endfunction

    function automatic answer_t apply_request(input logic [1:0] req,
                                              input logic [KEY_W-1:0] k,
                                              input logic [PAY_W-1:0] p);
        answer_t     ans;
        int unsigned sz;
        int unsigned pos;
        sz        = live_size();
        pos       = (k & HASH_MASK) % sz;
        ans.seq   = 0;
        ans.ok    = 1'b0;
        ans.found = '0;
        case (req)
            REQ_INSERT:
            begin
                // every insert counts, overwrites included
                if (shadow_count < sz)
                begin
                    shadow_valid[pos]   = 1'b1;
                    shadow_key[pos]     = k;
                    shadow_payload[pos] = p;
                    shadow_count++;
                    ans.ok = 1'b1;
                end
            end
            REQ_DIRECT:
            begin
                if (shadow_valid[pos])
                begin
                    ans.ok    = 1'b1;
                    ans.found = shadow_payload[pos];
                end
            end
            REQ_PROBE:
            begin
                for (int i = 0; i < sz; i++)
                begin
                    if (!shadow_valid[pos])
                        break;
                    if (shadow_key[pos] == k)
                    begin
                        ans.ok    = 1'b1;
                        ans.found = shadow_payload[pos];
                        break;
                    end
                    pos = (pos + 1 == sz) ? 0 : pos + 1;
                end
            end
            default: ;
        endcase
        return ans;
    endfunction

    // mostly keys already stored, same-home twins and sign-bit twins
    function automatic logic [KEY_W-1:0] pick_key();
        logic [KEY_W-1:0] base;
        int unsigned      roll;
        roll = $urandom_range(0, 9);
        if (key_pool.size() == 0 || roll < 3)
            return $urandom;
        base = key_pool[$urandom_range(0, key_pool.size() - 1)];
        if (roll < 6)
            return base;
        if (roll < 8)
            return base ^ ~HASH_MASK;
        return base + live_size() * $urandom_range(1, 8);
    endfunction

    task automatic report_mismatch(input string what);
        if (err_count < MAX_PRINTED)
            $display("%0t mismatch: %s", $time, what);
        err_count++;
    endtask

    // call at a rising edge; returns at the edge that took the transfer
    task automatic issue(input logic [1:0] req, input logic [KEY_W-1:0] k,
                         input logic [PAY_W-1:0] p, input bit typed,
                         input logic typed_ok, input logic [PAY_W-1:0] typed_found);
        answer_t ans;
        start    <= 1'b1;
        req_type <= req;
        key      <= k;
        payload  <= p;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        ans = apply_request(req, k, p);
        if (typed)
        begin
            ans.ok    = typed_ok;
            ans.found = typed_found;
        end
        ans.seq = items_sent;
        items_sent++;
        if (req == REQ_INSERT && ans.ok)
        begin
            key_pool.push_back(k);
            if (key_pool.size() > POOL_DEPTH)
                void'(key_pool.pop_front());
        end
        answers_due.push_back(ans);
    endtask

    task automatic pause(input int cycles);
        start <= 1'b0;
        repeat (cycles)
            @(posedge clk);
    endtask

    task automatic write_size(input logic [SIZE_W-1:0] sz);
        pause(1);
        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= sz;
        @(posedge clk);
        shadow_size = sz;
        cfg_we <= 1'b0;
    endtask

    task automatic random_request();
        int unsigned roll;
        logic [1:0]  req;
        roll = $urandom_range(0, 99);
        if (roll < 25)
            req = REQ_INSERT;
        else if (roll < 50)
            req = REQ_DIRECT;
        else if (roll < 96)
            req = REQ_PROBE;
        else
            req = REQ_UNKNOWN;
        issue(req, pick_key(), $urandom, 1'b0, 1'b0, '0);
    endtask

    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && done)
        begin
            if (answers_due.size() == 0)
                report_mismatch($sformatf("unexpected result ok %0b payload %h",
                                          ok, found_payload));
            else
            begin
                want = answers_due.pop_front();
                if (ok !== want.ok)
                    report_mismatch($sformatf("request %0d ok %0b, want %0b",
                                              want.seq, ok, want.ok));
                if (found_payload !== want.found)
                    report_mismatch($sformatf("request %0d payload %h, want %h",
                                              want.seq, found_payload, want.found));
            end
        end
    end

    initial
    begin
        int sent;
        int burst;
        foreach (shadow_valid[s])
        begin
            shadow_valid[s]   = 1'b0;
            shadow_key[s]     = '0;
            shadow_payload[s] = '0;
        end
        shadow_count = 0;
        shadow_size  = SIZE_RESET;

        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (PLAN[r])
        begin
            case (PLAN[r].kind)
                ROW_CFG:
                    write_size(PLAN[r].size);
                ROW_REQ:
                    issue(PLAN[r].req, PLAN[r].key, PLAN[r].pay, 1'b0, 1'b0, '0);
                default:
                    issue(PLAN[r].req, PLAN[r].key, PLAN[r].pay, 1'b1,
                          PLAN[r].ok, PLAN[r].found);
            endcase
            if ($urandom_range(0, 2) == 0)
                pause($urandom_range(1, 6));
        end

        foreach (PHASE_SIZES[ph])
        begin
            write_size(PHASE_SIZES[ph]);
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                burst = $urandom_range(1, 32);
                while (burst > 0 && sent < ITEMS_PER_PHASE)
                begin
                    random_request();
                    burst--;
                    sent++;
                end
                if ($urandom_range(0, 3) != 0)
                    pause($urandom_range(1, 24));
            end
        end

        pause(1);
        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (err_count == 0)
            $display("hash_table_linear_probe_test OK");
        else
            $display("hash_table_linear_probe_test NOT OK");
        $finish;
    end

    // worst case is every request a full-table probe; this is several times that
    initial
    begin
        #100ms;
        $display("hash_table_linear_probe_test NOT OK");
        $finish;
    end

endmodule
